// File: hdl/seglcd_pkg.sv
// Shared types and codes for the segment LCD frame buffer.
package seglcd_pkg;

  localparam int SEG_W  = 16;  // panel segment word per digit
  localparam int POS_W  = 3;   // position field width
  localparam int MASK_W = 8;   // dot / apostrophe mask width
  localparam int CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_SHIFT7 = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET7   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SHIFT14 = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET14  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DOTS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_APOS   = 3'd5;

  localparam logic [3:0] NIBBLE_MASK = 4'b1111;
  localparam logic [MASK_W-1:0] MARK_TOP = 8'b10000000;

  typedef enum logic [1:0] {
    OP_SHIFT,
    OP_SET,
    OP_DOTS,
    OP_APOS
  } op_kind_t;

  // Classified command as it travels from front to back.
  typedef struct packed {
    op_kind_t          kind;
    logic [SEG_W-1:0]  word;
    logic [POS_W-1:0]  pos;
    logic [MASK_W-1:0] mask;
  } op_t;

endpackage

// File: hdl/segment_lcd_frame_buffer.sv
// Top level of the segment LCD frame buffer.
//
// Usage:
//   Slave stream s_*: one command per transaction. s_tuser carries the
//   command code (shift7, set7, shift14, set14, dots, apostrophes).
//   Master stream m_*: one LCD driver RAM nibble write per transaction;
//   m_tlast marks the final write caused by a command.
// Timing:
//   A shift, or a dots/apostrophes command with a new mask, rewrites the
//   whole panel: 4*DIGITS writes (32 for eight digits), one per cycle
//   while m_tready is high. A set rewrites one digit: 4 writes. The emit
//   counter in the back end, one nibble per cycle unless stalled, sets the
//   throughput; the back end pops each command in its idle state between
//   refreshes. The first write passes the queue, the back end's idle state
//   and its output register. Unknown codes and set positions past the last
//   digit are dropped in the front and cost nothing; an unchanged mask
//   gives no writes but is still popped in the back end's idle state.
//   A two-entry command queue lets the front keep taking commands while
//   the back end is still refreshing.
// Reset: rst (synchronous) blanks all digits and clears both masks.
// Stall: while m_tready is low the pending write holds; the back end and
//   then the queue fill, and s_tready drops once the queue is full.
module segment_lcd_frame_buffer #(
  parameter int DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // seg_low[7:0], seg_high[13:8], position[16:14],
                                 // mark_mask[24:17], zero fill
  input  logic [2:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ram_address[4:0], ram_nibble[8:5], zero fill
  output logic        m_tlast    // last_write
);
  import seglcd_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  pop_op;

  seglcd_front #(.DIGITS(DIGITS)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  seglcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  seglcd_back #(.DIGITS(DIGITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .pop_op   (pop_op),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hdl/seglcd_front.sv
// Front end: accepts commands, remaps segment patterns, drops unknown codes and out-of-range sets.
module seglcd_front #(
  parameter int DIGITS = 8
) (
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,
  input  logic [seglcd_pkg::CMD_W-1:0] s_tuser,
  input  logic                      q_full,
  output logic                      push,
  output seglcd_pkg::op_t           push_op
);
  import seglcd_pkg::*;

  logic [7:0]       seg_low;
  logic [5:0]       seg_high;
  logic [POS_W-1:0] position;
  logic [MASK_W-1:0] mark_mask;
  logic [SEG_W-1:0] word7;
  logic [SEG_W-1:0] word14;
  logic             pos_ok;
  logic             keep;

  assign seg_low   = s_tdata[7:0];
  assign seg_high  = s_tdata[13:8];
  assign position  = s_tdata[16:14];
  assign mark_mask = s_tdata[24:17];

  // 7-segment: G lights word bits 9 and 14
  always_comb begin
    word7      = '0;
    word7[2:0] = seg_low[2:0];
    word7[7]   = seg_low[3];
    word7[6]   = seg_low[4];
    word7[5]   = seg_low[5];
    word7[9]   = seg_low[6];
    word7[14]  = seg_low[6];
    word7[3]   = seg_low[7];
  end

  always_comb begin
    word14      = '0;
    word14[2:0] = seg_low[2:0];
    word14[7]   = seg_low[3];
    word14[6]   = seg_low[4];
    word14[5]   = seg_low[5];
    word14[9]   = seg_low[6];
    word14[8]   = seg_low[7];
    word14[12]  = seg_high[0];
    word14[13]  = seg_high[1];
    word14[14]  = seg_high[2];
    word14[15]  = seg_high[3];
    word14[11]  = seg_high[4];
    word14[10]  = seg_high[5];
  end

  assign pos_ok = (32'(position) < DIGITS);

  always_comb begin
    push_op.kind = OP_SHIFT;
    push_op.word = word7;
    push_op.pos  = position;
    push_op.mask = mark_mask;
    keep         = 1'b1;
    unique case (s_tuser)
      CMD_SHIFT7: begin
        push_op.kind = OP_SHIFT;
      end
      CMD_SET7: begin
        push_op.kind = OP_SET;
        keep         = pos_ok;
      end
      CMD_SHIFT14: begin
        push_op.kind = OP_SHIFT;
        push_op.word = word14;
      end
      CMD_SET14: begin
        push_op.kind = OP_SET;
        push_op.word = word14;
        keep         = pos_ok;
      end
      CMD_DOTS: begin
        push_op.kind = OP_DOTS;
      end
      CMD_APOS: begin
        push_op.kind = OP_APOS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready && keep;

endmodule

// File: hdl/seglcd_queue.sv
// Two-entry queue of classified commands between front and back.
module seglcd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  seglcd_pkg::op_t push_op,
  output logic            full,
  input  logic            pop,
  output seglcd_pkg::op_t pop_op,
  output logic            empty
);
  import seglcd_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/seglcd_back.sv
// Back end: holds the frame, applies commands and streams nibble writes.
module seglcd_back #(
  parameter int DIGITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  seglcd_pkg::op_t pop_op,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic            m_tlast
);
  import seglcd_pkg::*;

  localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [DW-1:0] LAST_DIGIT = DW'(DIGITS - 1);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t           state;
  logic [SEG_W-1:0] digit_segments [DIGITS];
  logic [MASK_W-1:0] dot_mask;
  logic [MASK_W-1:0] apostrophe_mask;
  logic [DW-1:0]    cur_digit;
  logic [DW-1:0]    end_digit;
  logic [1:0]       nibble_idx;

  logic [3:0]       mark_idx;
  logic             dot_on;
  logic             apos_on;
  logic [SEG_W-1:0] cur_word;
  logic [3:0]       cur_nibble;
  logic             out_free;
  logic             is_last;

  // mask bit i+1 marks digit i; bit 0 marks the rightmost digit
  always_comb begin
    mark_idx = 4'(cur_digit) + 4'd1;
    dot_on   = ((cur_digit == LAST_DIGIT) && dot_mask[0]) ||
               ((mark_idx < 4'd8) && dot_mask[mark_idx[2:0]]);
    apos_on  = ((cur_digit == LAST_DIGIT) && apostrophe_mask[0]) ||
               ((mark_idx < 4'd8) && apostrophe_mask[mark_idx[2:0]]);
    cur_word = digit_segments[cur_digit];
    if (dot_on)  cur_word[3] = 1'b1;
    if (apos_on) cur_word[4] = 1'b1;
    cur_nibble = 4'(cur_word >> {nibble_idx, 2'b00}) & NIBBLE_MASK;
  end

  assign out_free = !m_tvalid || m_tready;
  assign is_last  = (cur_digit == end_digit) && (nibble_idx == 2'd3);
  assign pop      = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      m_tdata         <= '0;
      m_tlast         <= 1'b0;
      dot_mask        <= '0;
      apostrophe_mask <= '0;
      cur_digit       <= '0;
      end_digit       <= '0;
      nibble_idx      <= '0;
      for (int d = 0; d < DIGITS; d++) digit_segments[d] <= '0;
    end else begin
      // while emitting, out_free covers the accepted write
      if (m_tvalid && m_tready && (state != S_EMIT)) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            nibble_idx <= '0;
            unique case (pop_op.kind)
              OP_SHIFT: begin
                for (int d = 0; d < DIGITS - 1; d++) begin
                  digit_segments[d] <= digit_segments[d + 1];
                end
                digit_segments[DIGITS-1] <= pop_op.word;
                cur_digit <= '0;
                end_digit <= LAST_DIGIT;
                state     <= S_EMIT;
              end
              OP_SET: begin
                digit_segments[DW'(pop_op.pos)] <= pop_op.word;
                cur_digit <= DW'(pop_op.pos);
                end_digit <= DW'(pop_op.pos);
                state     <= S_EMIT;
              end
              OP_DOTS: begin
                cur_digit <= '0;
                end_digit <= LAST_DIGIT;
                if (pop_op.mask != dot_mask) begin
                  dot_mask <= pop_op.mask;
                  state    <= S_EMIT;
                end
              end
              OP_APOS: begin
                cur_digit <= '0;
                end_digit <= LAST_DIGIT;
                if (pop_op.mask != apostrophe_mask) begin
                  apostrophe_mask <= pop_op.mask;
                  state           <= S_EMIT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {7'd0, cur_nibble, 5'({cur_digit, nibble_idx})};
            m_tlast    <= is_last;
            nibble_idx <= nibble_idx + 2'd1;
            if (nibble_idx == 2'd3) cur_digit <= cur_digit + DW'(1);
            if (is_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
